// File: rtl/rle8_escape_decoder_core_assert.svh
// assertion macros shared by the rle8 decoder modules
`ifndef RLE8_ESCAPE_DECODER_CORE_ASSERT_SVH
`define RLE8_ESCAPE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk_i and held off during reset
`define RLE8_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLE8_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rle8_pkg.sv
// shared types and constants of the rle8 escape decoder
`timescale 1ns / 1ps
package rle8_pkg;

  localparam logic [7:0]  CodeNewline = 8'd0;
  localparam logic [7:0]  CodeEnd     = 8'd1;
  localparam logic [7:0]  CodeMove    = 8'd2;
  localparam logic [7:0]  CodeLitMin  = 8'd3;
  localparam logic [7:0]  EscapeByte  = 8'd0;
  localparam logic [15:0] PitchReset  = 16'd320;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_VALUE,
    PH_CODE,
    PH_MOVE_X,
    PH_MOVE_Y,
    PH_LITERAL
  } phase_e;

  typedef enum logic [2:0] {
    OP_FILL,
    OP_NEWLINE,
    OP_MOVE,
    OP_MOVE_LINE,
    OP_END
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [23:0] amount;
    logic [7:0]  value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/rle8_escape_decoder_core.sv
// top level of the rle8 escape decoder
// Usage:
//   in channel: one compressed byte per word on in_byte_i, valid/ready.
//   out channel: one command per word (write_offset_o, run_length_o,
//   pixel_value_o, is_end_o, overflow_o), valid/ready. Runs and literal
//   bytes give fill words; the end code gives a word with is_end_o set,
//   the decoded size in write_offset_o and zero length and value.
//   cfg: cfg_we_i writes cfg_wdata_i into the line pitch, no wait. Write
//   it only while no word is in flight.
// Timing: a word that yields a result is written into the command queue
//   on acceptance and then loaded into the output register that drives
//   out_valid_o. One byte per cycle sustained: the parser takes a byte
//   every cycle and the executor pops one command per cycle, so the
//   four-entry queue never fills without a stall.
// Stall: while the receiver holds out_ready_i low the queue fills; once
//   full, in_ready_o drops. Newline and move words at the head still drain.
// Reset: pitch 320, position, line base and wrap flag cleared, queue empty.
`timescale 1ns / 1ps
module rle8_escape_decoder_core #(
  parameter int OFFSET_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] write_offset_o,
  output logic [7:0]  run_length_o,
  output logic [7:0]  pixel_value_o,
  output logic        is_end_o,
  output logic        overflow_o
);
  import rle8_pkg::*;

  logic      push, pop;
  cmd_t      cmd_in, cmd_head;
  q_status_t q_status;

  rle8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  rle8_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (pop),
    .cmd_o   (cmd_head),
    .status_o(q_status)
  );

  rle8_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_status.empty),
    .cmd_i         (cmd_head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .write_offset_o(write_offset_o),
    .run_length_o  (run_length_o),
    .pixel_value_o (pixel_value_o),
    .is_end_o      (is_end_o),
    .overflow_o    (overflow_o)
  );

endmodule

// File: rtl/rle8_front.sv
// byte parser: tracks the escape phase and turns words into commands
`timescale 1ns / 1ps
`include "rle8_escape_decoder_core_assert.svh"
module rle8_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  rle8_pkg::q_status_t q_status_i,
  output logic              push_o,
  output rle8_pkg::cmd_t    cmd_o
);
  import rle8_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] pitch_q;
  logic        take;
  logic [23:0] dy;

  assign in_ready_o = !q_status_i.full;
  assign take       = in_valid_i && in_ready_o;
  assign dy         = 24'(in_byte_i) * 24'(pitch_q);

  // next phase
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (take) begin
      case (phase_q)
        PH_COUNT: begin
          if (in_byte_i != EscapeByte) begin
            count_d = in_byte_i;
            phase_d = PH_VALUE;
          end else begin
            phase_d = PH_CODE;
          end
        end
        PH_VALUE: begin
          count_d = '0;
          phase_d = PH_COUNT;
        end
        PH_CODE: begin
          if (in_byte_i >= CodeLitMin) begin
            count_d = in_byte_i;
            phase_d = PH_LITERAL;
          end else if (in_byte_i == CodeMove) begin
            phase_d = PH_MOVE_X;
          end else begin
            count_d = '0;
            phase_d = PH_COUNT;
          end
        end
        PH_MOVE_X: phase_d = PH_MOVE_Y;
        PH_MOVE_Y: phase_d = PH_COUNT;
        PH_LITERAL: begin
          count_d = count_q - 8'd1;
          if (count_q == 8'd1) begin
            phase_d = PH_COUNT;
          end
        end
        default: begin
          count_d = '0;
          phase_d = PH_COUNT;
        end
      endcase
    end
  end

  // command words for the back end
  always_comb begin
    push_o       = 1'b0;
    cmd_o.op     = OP_FILL;
    cmd_o.amount = 24'(count_q);
    cmd_o.value  = in_byte_i;
    if (take) begin
      case (phase_q)
        PH_VALUE: push_o = 1'b1;
        PH_LITERAL: begin
          push_o       = 1'b1;
          cmd_o.amount = 24'd1;
        end
        PH_CODE: begin
          if (in_byte_i == CodeNewline) begin
            push_o       = 1'b1;
            cmd_o.op     = OP_NEWLINE;
            cmd_o.amount = 24'(pitch_q);
          end else if (in_byte_i == CodeEnd) begin
            push_o   = 1'b1;
            cmd_o.op = OP_END;
          end
        end
        PH_MOVE_X: begin
          push_o       = 1'b1;
          cmd_o.op     = OP_MOVE;
          cmd_o.amount = 24'(in_byte_i);
        end
        PH_MOVE_Y: begin
          push_o       = 1'b1;
          cmd_o.op     = OP_MOVE_LINE;
          cmd_o.amount = dy;
        end
        default: push_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_COUNT;
      count_q <= '0;
      pitch_q <= PitchReset;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        pitch_q <= cfg_wdata_i;
      end
    end
  end

  `RLE8_ASSERT_IMP(a_lit_count, phase_q == PH_LITERAL, count_q != 8'd0, "literal phase with zero count")
  `RLE8_ASSERT_IMP(a_no_push_full, push_o, !q_status_i.full, "command pushed into full queue")

endmodule

// File: rtl/rle8_cmd_queue.sv
// small command queue between parser and executor
`timescale 1ns / 1ps
`include "rle8_escape_decoder_core_assert.svh"
module rle8_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rle8_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output rle8_pkg::cmd_t      cmd_o,
  output rle8_pkg::q_status_t status_o
);
  import rle8_pkg::*;

  cmd_t                 mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   fill_q, fill_d;
  logic                 do_pop;

  assign status_o.full  = (fill_q == (QueuePtrW + 1)'(QueueDepth));
  assign status_o.empty = (fill_q == '0);
  assign do_pop         = pop_i && !status_o.empty;
  assign cmd_o          = mem[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!push_i && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  `RLE8_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= (QueuePtrW + 1)'(QueueDepth), "queue fill out of range")
  `RLE8_ASSERT_IMP(a_ptr_match, fill_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with skewed pointers")

endmodule

// File: rtl/rle8_back.sv
// executor: position arithmetic, wrap flag and output register
`timescale 1ns / 1ps
`include "rle8_escape_decoder_core_assert.svh"
module rle8_back #(
  parameter int OFFSET_BITS = 24
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  rle8_pkg::cmd_t cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [23:0]    write_offset_o,
  output logic [7:0]     run_length_o,
  output logic [7:0]     pixel_value_o,
  output logic           is_end_o,
  output logic           overflow_o
);
  import rle8_pkg::*;

  localparam int SumW = ((OFFSET_BITS > 24) ? OFFSET_BITS : 24) + 1;

  logic [OFFSET_BITS-1:0] pos_q, pos_d, base_q, base_d;
  logic                   wrap_q, wrap_d;
  logic [SumW-1:0]        pos_sum, base_sum;
  logic                   pos_wrap, base_wrap, emits, load;
  logic                   out_valid_q, out_valid_d;
  logic [23:0]            offset_q, offset_d;
  logic [7:0]             len_q, len_d, value_q, value_d;
  logic                   end_q, end_d, ovf_q, ovf_d;

  assign pos_sum   = SumW'(pos_q) + SumW'(cmd_i.amount);
  assign base_sum  = SumW'(base_q) + SumW'(cmd_i.amount);
  assign pos_wrap  = |pos_sum[SumW-1:OFFSET_BITS];
  assign base_wrap = |base_sum[SumW-1:OFFSET_BITS];

  assign emits = (cmd_i.op == OP_FILL) || (cmd_i.op == OP_END);
  // silent commands never wait on the output side
  assign pop_o = cmd_valid_i && (!emits || !out_valid_q || out_ready_i);
  assign load  = pop_o && emits;

  always_comb begin
    pos_d    = pos_q;
    base_d   = base_q;
    wrap_d   = wrap_q;
    offset_d = 24'(pos_q);
    len_d    = cmd_i.amount[7:0];
    value_d  = cmd_i.value;
    end_d    = 1'b0;
    ovf_d    = wrap_q | pos_wrap;
    if (pop_o) begin
      case (cmd_i.op)
        OP_FILL: begin
          pos_d  = pos_sum[OFFSET_BITS-1:0];
          wrap_d = wrap_q | pos_wrap;
        end
        OP_NEWLINE: begin
          base_d = base_sum[OFFSET_BITS-1:0];
          pos_d  = base_sum[OFFSET_BITS-1:0];
          wrap_d = wrap_q | base_wrap;
        end
        OP_MOVE: begin
          pos_d  = pos_sum[OFFSET_BITS-1:0];
          wrap_d = wrap_q | pos_wrap;
        end
        OP_MOVE_LINE: begin
          base_d = base_sum[OFFSET_BITS-1:0];
          pos_d  = pos_sum[OFFSET_BITS-1:0];
          wrap_d = wrap_q | pos_wrap | base_wrap;
        end
        OP_END: begin
          len_d   = '0;
          value_d = '0;
          end_d   = 1'b1;
          ovf_d   = wrap_q;
          pos_d   = '0;
          base_d  = '0;
          wrap_d  = 1'b0;
        end
        default: wrap_d = wrap_q;
      endcase
    end
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      base_q      <= '0;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      base_q      <= base_d;
      wrap_q      <= wrap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      offset_q <= offset_d;
      len_q    <= len_d;
      value_q  <= value_d;
      end_q    <= end_d;
      ovf_q    <= ovf_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_offset_o = offset_q;
  assign run_length_o   = len_q;
  assign pixel_value_o  = value_q;
  assign is_end_o       = end_q;
  assign overflow_o     = ovf_q;

  `RLE8_ASSERT_NXT(a_end_clears, pop_o && cmd_i.op == OP_END, pos_q == '0 && base_q == '0 && !wrap_q, "end word left state")
  `RLE8_ASSERT_NXT(a_load_valid, load, out_valid_q, "loaded result not presented")

endmodule
